// ===== design/epdrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EPD refresh sequencer package
// Beat types, action and stage codes, command tables and the control/status
// structs shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package epdrs_pkg;

  // Defaults for top-level parameters
  localparam int unsigned ImageBytesDef = 16;
  localparam logic [7:0]  BudgetReloadRst = 8'hFF;

  // Input actions
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_COMMIT = 2'd1;
  localparam logic [1:0] ACT_POLL   = 2'd2;
  localparam logic [1:0] ACT_INIT   = 2'd3;

  // Update stages
  localparam logic [2:0] STAGE_IDLE  = 3'd0;
  localparam logic [2:0] STAGE_PING  = 3'd1;
  localparam logic [2:0] STAGE_SETUP = 3'd2;
  localparam logic [2:0] STAGE_FRAME = 3'd3;
  localparam logic [2:0] STAGE_CLOSE = 3'd4;

  // Input beat
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic       ready_line;
  } in_t;

  // Output beat
  typedef struct packed {
    logic       word_valid;
    logic       is_data;
    logic [7:0] word_byte;
    logic       panel_reset;
    logic [2:0] stage_now;
    logic       last;
  } out_t;

  // Command word segments
  typedef enum logic [2:0] {
    SEG_PING,
    SEG_INIT,
    SEG_WORK,
    SEG_HEAD,
    SEG_TAIL,
    SEG_CLOSE
  } seg_e;

  // What kind of beat goes into the output register
  typedef enum logic [1:0] {
    EMIT_STATUS,
    EMIT_TAB,
    EMIT_IMG
  } emit_e;

  // Command tables
  localparam logic [7:0] PING_TAB [5] = '{8'h7B, 8'h81, 8'hE4, 8'hE7, 8'h08};
  localparam logic [7:0] INIT_TAB [14] = '{8'h82, 8'h68, 8'h50, 8'hE8, 8'hD0, 8'hA8,
                                           8'h65, 8'h7B, 8'h81, 8'hE4, 8'hE7, 8'h08,
                                           8'hAC, 8'h2B};
  localparam logic [7:0] WORK_TAB [9] = '{8'h82, 8'h80, 8'h00, 8'hC0, 8'h80, 8'h80,
                                          8'h62, 8'hAC, 8'h2B};
  localparam logic [7:0] HEAD_TAB  [3] = '{8'h40, 8'hA9, 8'hA8};
  localparam logic [7:0] TAIL_TAB  [3] = '{8'hAB, 8'hAA, 8'hAF};
  localparam logic [7:0] CLOSE_TAB [3] = '{8'hAE, 8'h28, 8'hAD};

  // Segment length in words
  function automatic logic [3:0] seg_len(input seg_e seg);
    logic [3:0] len;
    len = 4'd3;
    unique case (seg)
      SEG_PING: len = 4'd5;
      SEG_INIT: len = 4'd14;
      SEG_WORK: len = 4'd9;
      default:  len = 4'd3;
    endcase
    return len;
  endfunction

  // Word k of a segment; out-of-range positions read as zero
  function automatic logic [7:0] seg_word(input seg_e seg, input logic [3:0] k);
    logic [7:0] w;
    w = 8'h00;
    unique case (seg)
      SEG_PING:  if (k < 4'd5)  w = PING_TAB[k[2:0]];
      SEG_INIT:  if (k < 4'd14) w = INIT_TAB[k];
      SEG_WORK:  if (k < 4'd9)  w = WORK_TAB[k];
      SEG_HEAD:  if (k < 4'd3)  w = HEAD_TAB[k[1:0]];
      SEG_TAIL:  if (k < 4'd3)  w = TAIL_TAB[k[1:0]];
      default:   if (k < 4'd3)  w = CLOSE_TAB[k[1:0]];
    endcase
    return w;
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic  load;         // latch input beat
    logic  img_write;    // image byte write
    logic  reinit;       // panel re-initialization
    logic  cnt_clr;
    logic  cnt_inc;
    logic  rd_en;        // read image and shadow at counter
    logic  cmp_step;     // compare one byte, copy into shadow
    logic  commit_done;  // budget / stage update after the scan
    logic  poll_adv;     // advance stage for a ready poll
    logic  stage_clear;  // stray stage back to idle
    logic  emit;         // load output register
    emit_e emit_kind;
    seg_e  seg;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       ready_line;
    logic [2:0] stage;
    logic       full_init_done;
    logic       out_free;
    logic       tab_last;
    logic       img_last;
  } dp_sts_t;

endpackage

// ===== design/epdrs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EPD refresh sequencer datapath
// Image and shadow memories, stage/budget state, word counter and the output
// register, all driven by controller commands.
// ----------------------------------------------------------------------------
module epdrs_dp #(
  parameter int unsigned IMAGE_BYTES = epdrs_pkg::ImageBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  epdrs_pkg::in_t       in_data_i,
  input  epdrs_pkg::ctl_cmd_t  cmd_i,
  output epdrs_pkg::dp_sts_t   sts_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output epdrs_pkg::out_t      out_data_o
);
  import epdrs_pkg::*;

  localparam int unsigned IW = (IMAGE_BYTES > 1) ? $clog2(IMAGE_BYTES) : 1;
  localparam int unsigned CW = (IW > 4) ? IW : 4;

  // Registers
  in_t             item_q;
  logic [2:0]      stage_q, stage_d;
  logic [7:0]      budget_q, budget_d;
  logic            fid_q, fid_d;
  logic            diff_q;
  logic            rst_flag_q;
  logic [7:0]      reload_q;
  logic [CW-1:0]   cnt_q;
  logic [7:0]      img_rd_q, sh_rd_q;
  out_t            out_q;
  logic            out_valid_q;

  // Memories with per-entry valid bits
  logic [7:0]             img_mem [IMAGE_BYTES];
  logic [7:0]             sh_mem  [IMAGE_BYTES];
  logic [IMAGE_BYTES-1:0] img_vld_q, sh_vld_q;

  logic [CW-1:0] idx_ext;
  logic          idx_ok;
  logic [IW-1:0] rd_addr;
  logic          do_reinit;
  logic          img_we;
  logic [IW-1:0] img_wa;
  logic [7:0]    img_wd;
  logic          tab_last, img_last, out_free;
  out_t          beat;

  assign idx_ext  = CW'(item_q.byte_index);
  assign idx_ok   = ({1'b0, idx_ext} < (CW+1)'(IMAGE_BYTES));
  assign rd_addr  = cnt_q[IW-1:0];
  assign tab_last = (cnt_q == CW'(seg_len(cmd_i.seg) - 4'd1));
  assign img_last = (cnt_q == CW'(IMAGE_BYTES - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // Re-init from a panel init request or a commit with the budget spent
  assign do_reinit = cmd_i.reinit ||
                     (cmd_i.commit_done && diff_q && (budget_q == 8'd0));

  // Image write port: byte write or clearing the last byte on re-init
  always_comb begin
    img_we = 1'b0;
    img_wa = idx_ext[IW-1:0];
    img_wd = item_q.byte_value;
    if (do_reinit) begin
      img_we = 1'b1;
      img_wa = IW'(IMAGE_BYTES - 1);
      img_wd = 8'h00;
    end else if (cmd_i.img_write && idx_ok) begin
      img_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[img_wa] <= img_wd;
    end
    if (cmd_i.cmp_step) begin
      sh_mem[rd_addr] <= img_rd_q;
    end
    if (cmd_i.rd_en) begin
      img_rd_q <= img_vld_q[rd_addr] ? img_mem[rd_addr] : 8'h00;
      sh_rd_q  <= sh_vld_q[rd_addr] ? sh_mem[rd_addr] : 8'h00;
    end
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.emit) begin
      out_q <= beat;
    end
  end

  // Stage, budget and full-init flag
  always_comb begin
    stage_d  = stage_q;
    budget_d = budget_q;
    fid_d    = fid_q;
    if (do_reinit) begin
      stage_d  = STAGE_PING;
      budget_d = reload_q;
      fid_d    = 1'b0;
    end else if (cmd_i.commit_done && diff_q) begin
      stage_d  = STAGE_PING;
      budget_d = budget_q - 8'd1;
    end else if (cmd_i.poll_adv) begin
      case (stage_q)
        STAGE_PING:  stage_d = STAGE_SETUP;
        STAGE_SETUP: stage_d = STAGE_FRAME;
        STAGE_FRAME: begin
          if (fid_q) begin
            stage_d = STAGE_CLOSE;
          end else begin
            stage_d = STAGE_SETUP;
            fid_d   = 1'b1;
          end
        end
        default:     stage_d = STAGE_IDLE;
      endcase
    end else if (cmd_i.stage_clear) begin
      stage_d = STAGE_IDLE;
    end
  end

  // Output beat
  always_comb begin
    beat           = '0;
    beat.stage_now = stage_q;
    case (cmd_i.emit_kind)
      EMIT_TAB: begin
        beat.word_valid = 1'b1;
        beat.word_byte  = seg_word(cmd_i.seg, cnt_q[3:0]);
        beat.last       = tab_last && (cmd_i.seg != SEG_HEAD);
      end
      EMIT_IMG: begin
        beat.word_valid = 1'b1;
        beat.is_data    = 1'b1;
        beat.word_byte  = img_rd_q;
      end
      default: begin
        beat.panel_reset = rst_flag_q;
        beat.last        = 1'b1;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STAGE_IDLE;
      budget_q    <= 8'd0;
      fid_q       <= 1'b0;
      diff_q      <= 1'b0;
      rst_flag_q  <= 1'b0;
      reload_q    <= BudgetReloadRst;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      img_vld_q   <= '0;
      sh_vld_q    <= '0;
    end else begin
      stage_q  <= stage_d;
      budget_q <= budget_d;
      fid_q    <= fid_d;
      if (cfg_we_i) begin
        reload_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        diff_q     <= 1'b0;
        rst_flag_q <= 1'b0;
      end else begin
        if (cmd_i.cmp_step && (img_rd_q != sh_rd_q)) begin
          diff_q <= 1'b1;
        end
        if (do_reinit) begin
          rst_flag_q <= 1'b1;
        end
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (img_we) begin
        img_vld_q[img_wa] <= 1'b1;
      end
      if (cmd_i.cmp_step) begin
        sh_vld_q[rd_addr] <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status to controller
  always_comb begin
    sts_o.action         = item_q.action;
    sts_o.ready_line     = item_q.ready_line;
    sts_o.stage          = stage_q;
    sts_o.full_init_done = fid_q;
    sts_o.out_free       = out_free;
    sts_o.tab_last       = tab_last;
    sts_o.img_last       = img_last;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/epdrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EPD refresh sequencer controller
// Takes one input beat at a time and steps the datapath through the commit
// scan or the word sequence of a poll, then issues the final beat.
// ----------------------------------------------------------------------------
module epdrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  epdrs_pkg::dp_sts_t   sts_i,
  output epdrs_pkg::ctl_cmd_t  cmd_o
);
  import epdrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_STATUS,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_CMP_END,
    ST_TAB,
    ST_IMG_RD
  } state_e;

  // One extra state for the image word beat
  typedef enum logic {
    IMG_PH_RD,
    IMG_PH_EMIT
  } img_ph_e;

  state_e  state_q, state_d;
  seg_e    seg_q, seg_d;
  img_ph_e ph_q, ph_d;
  logic    stage_live;

  assign in_ready_o = (state_q == ST_IDLE);
  assign stage_live = (sts_i.stage == STAGE_PING)  || (sts_i.stage == STAGE_SETUP) ||
                      (sts_i.stage == STAGE_FRAME) || (sts_i.stage == STAGE_CLOSE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    ph_d    = ph_q;
    cmd_o   = '0;
    cmd_o.emit_kind = EMIT_STATUS;
    cmd_o.seg       = seg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.action)
          ACT_WRITE: begin
            cmd_o.img_write = 1'b1;
            state_d         = ST_STATUS;
          end
          ACT_COMMIT: begin
            if (sts_i.stage == STAGE_IDLE) begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_CMP_RD;
            end else begin
              state_d = ST_STATUS;
            end
          end
          ACT_POLL: begin
            if (sts_i.ready_line && stage_live) begin
              cmd_o.poll_adv = 1'b1;
              cmd_o.cnt_clr  = 1'b1;
              state_d        = ST_TAB;
              unique case (sts_i.stage)
                STAGE_PING:  seg_d = SEG_PING;
                STAGE_SETUP: seg_d = sts_i.full_init_done ? SEG_WORK : SEG_INIT;
                STAGE_FRAME: seg_d = SEG_HEAD;
                default:     seg_d = SEG_CLOSE;
              endcase
            end else begin
              cmd_o.stage_clear = sts_i.ready_line;
              state_d           = ST_STATUS;
            end
          end
          default: begin
            cmd_o.reinit = 1'b1;
            state_d      = ST_STATUS;
          end
        endcase
      end
      ST_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      // Commit scan: read a byte pair, then compare and copy
      ST_CMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.img_last) begin
          state_d = ST_CMP_END;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_CMP_RD;
        end
      end
      ST_CMP_END: begin
        cmd_o.commit_done = 1'b1;
        state_d           = ST_STATUS;
      end
      // Command words from a table, one per free output slot
      ST_TAB: begin
        cmd_o.emit_kind = EMIT_TAB;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.tab_last) begin
            if (seg_q == SEG_HEAD) begin
              cmd_o.cnt_clr = 1'b1;
              ph_d          = IMG_PH_RD;
              state_d       = ST_IMG_RD;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      // Image data words: read, then emit
      default: begin
        if (ph_q == IMG_PH_RD) begin
          cmd_o.rd_en = 1'b1;
          ph_d        = IMG_PH_EMIT;
        end else begin
          cmd_o.emit_kind = EMIT_IMG;
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            ph_d       = IMG_PH_RD;
            if (sts_i.img_last) begin
              cmd_o.cnt_clr = 1'b1;
              seg_d         = SEG_TAIL;
              state_d       = ST_TAB;
            end else begin
              cmd_o.cnt_inc = 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seg_q   <= SEG_PING;
      ph_q    <= IMG_PH_RD;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      ph_q    <= ph_d;
    end
  end

endmodule

// ===== design/epd_refresh_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EPD refresh sequencer core
// Segment image store with commit/compare against a shadow copy, refresh
// budget and staged emission of 9-bit panel command/data words.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  beat
//  in        in_valid_i / in_ready_o          input      in_t, one request
//  out       out_valid_o / out_ready_i        output     out_t, one word/status
//  cfg       cfg_we_i / cfg_wdata_i           input      budget reload value
//
// One request at a time. Write, panel init and no-op steps pass dispatch, then a status beat.
// A commit scans the image through one read port, reading then comparing each byte.
// A poll emits table words one per cycle while the output is free; image words
// are each read from memory, then output, between the head and tail words of stage 3.
// Output stalls hold the sequence; the output register lets the next request
// be taken while the final beat waits. Reset clears the stores via valid bits.
// ----------------------------------------------------------------------------
module epd_refresh_sequencer_core #(
  parameter int unsigned IMAGE_BYTES = epdrs_pkg::ImageBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  epdrs_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output epdrs_pkg::out_t  out_data_o,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i
);
  import epdrs_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencing control
  epdrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, state and output register
  epdrs_dp #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
